[sv/websocket_frame_deframer_core_macros.svh]
// assertion macros shared by the deframer modules
// clock clk_i and active low reset rst_ni are taken from the including scope
`ifndef WEBSOCKET_FRAME_DEFRAMER_CORE_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_CORE_MACROS_SVH

// same-cycle implication
`define WSFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WSFD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/wsfd_pkg.sv]
`default_nettype none

package wsfd_pkg;

  // parser phases
  localparam logic [2:0] PH_HDR0    = 3'd0;
  localparam logic [2:0] PH_HDR1    = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_MASK    = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  // frame opcodes that produce output
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  // 7-bit length codes that announce an extended length
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // one output transaction
  typedef struct packed {
    logic [7:0] data_byte;
    logic [3:0] frame_opcode;
    logic       has_byte;
    logic       last;
  } res_t;

  function automatic logic opcode_known(input logic [3:0] op);
    return (op == OP_TEXT) || (op == OP_BINARY) || (op == OP_CLOSE) ||
           (op == OP_PING) || (op == OP_PONG);
  endfunction

endpackage

`default_nettype wire

[sv/wsfd_stream_if.sv]
`default_nettype none

// received byte channel
interface wsfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// result channel
interface wsfd_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [3:0] frame_opcode;
  logic       has_byte;
  logic       last;

  modport source (output valid, output data_byte, output frame_opcode,
                  output has_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input frame_opcode,
                  input has_byte, input last, output ready);
endinterface

`default_nettype wire

[sv/wsfd_in_stage.sv]
`default_nettype none

module wsfd_in_stage (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  input  wire logic [7:0] rx_byte_i,
  output logic            ready_o,
  input  wire logic       adv_i,
  output logic            vld_o,
  output logic [7:0]      rx_byte_o
);

  logic       vld_q;
  logic [7:0] byte_q;

  // stage is free when empty or when its byte moves on this cycle
  assign ready_o = !vld_q || adv_i;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  // byte register
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      byte_q <= rx_byte_i;
    end
  end

  assign vld_o     = vld_q;
  assign rx_byte_o = byte_q;

endmodule

`default_nettype wire

[sv/wsfd_parser.sv]
`default_nettype none

`include "websocket_frame_deframer_core_macros.svh"

module wsfd_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        adv_i,
  input  wire logic [7:0]  rx_byte_i,
  output logic             res_vld_o,
  output wsfd_pkg::res_t   res_o
);

  import wsfd_pkg::*;

  logic [2:0]  phase_q,  phase_d;
  logic [3:0]  op_q,     op_d;
  logic        mask_on_q, mask_on_d;
  logic [63:0] rem_q,    rem_d;
  logic [2:0]  hbl_q,    hbl_d;
  logic [31:0] key_q,    key_d;
  logic [1:0]  pos_q,    pos_d;

  logic        fin_len;
  logic [63:0] len_v;
  logic        fin_hdr;
  logic [63:0] hdr_len;
  logic [7:0]  key_byte;

  // key byte for the current payload position, first key byte on top
  always_comb begin
    case (pos_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  // next state and result for one received byte
  always_comb begin
    phase_d   = phase_q;
    op_d      = op_q;
    mask_on_d = mask_on_q;
    rem_d     = rem_q;
    hbl_d     = hbl_q;
    key_d     = key_q;
    pos_d     = pos_q;
    fin_len   = 1'b0;
    len_v     = '0;
    fin_hdr   = 1'b0;
    hdr_len   = '0;
    res_vld_o = 1'b0;
    res_o     = '{data_byte: 8'd0, frame_opcode: op_q, has_byte: 1'b0, last: 1'b1};

    unique case (phase_q)
      PH_HDR1: begin
        mask_on_d = rx_byte_i[7];
        rem_d     = '0;
        if (rx_byte_i[6:0] == LEN_EXT16) begin
          hbl_d   = 3'd1;
          phase_d = PH_EXTLEN;
        end else if (rx_byte_i[6:0] == LEN_EXT64) begin
          hbl_d   = 3'd7;
          phase_d = PH_EXTLEN;
        end else begin
          rem_d   = {57'd0, rx_byte_i[6:0]};
          fin_len = 1'b1;
          len_v   = {57'd0, rx_byte_i[6:0]};
        end
      end
      PH_EXTLEN: begin
        rem_d = {rem_q[55:0], rx_byte_i};
        if (hbl_q == 3'd0) begin
          fin_len = 1'b1;
          len_v   = {rem_q[55:0], rx_byte_i};
        end else begin
          hbl_d = hbl_q - 3'd1;
        end
      end
      PH_MASK: begin
        key_d = {key_q[23:0], rx_byte_i};
        if (hbl_q == 3'd0) begin
          fin_hdr = 1'b1;
          hdr_len = rem_q;
        end else begin
          hbl_d = hbl_q - 3'd1;
        end
      end
      PH_PAYLOAD: begin
        pos_d = pos_q + 2'd1;
        rem_d = rem_q - 64'd1;
        if (rem_q == 64'd1) begin
          phase_d = PH_HDR0;
        end
        res_vld_o          = opcode_known(op_q);
        res_o.data_byte    = mask_on_q ? (rx_byte_i ^ key_byte) : rx_byte_i;
        res_o.has_byte     = 1'b1;
        res_o.last         = (rem_q == 64'd1);
      end
      default: begin
        // first header byte, also recovers from unused phase codes
        op_d      = rx_byte_i[3:0];
        mask_on_d = 1'b0;
        rem_d     = '0;
        hbl_d     = 3'd0;
        key_d     = '0;
        pos_d     = 2'd0;
        phase_d   = PH_HDR1;
      end
    endcase

    // length known: fetch the mask key or finish the header
    if (fin_len) begin
      key_d = '0;
      if (mask_on_d) begin
        hbl_d   = 3'd3;
        phase_d = PH_MASK;
      end else begin
        fin_hdr = 1'b1;
        hdr_len = len_v;
      end
    end

    // header done: empty frame marker or payload
    if (fin_hdr) begin
      pos_d = 2'd0;
      if (hdr_len == 64'd0) begin
        phase_d   = PH_HDR0;
        res_vld_o = opcode_known(op_q);
      end else begin
        phase_d = PH_PAYLOAD;
      end
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HDR0;
      op_q      <= '0;
      mask_on_q <= 1'b0;
      rem_q     <= '0;
      hbl_q     <= '0;
      key_q     <= '0;
      pos_q     <= '0;
    end else if (adv_i) begin
      phase_q   <= phase_d;
      op_q      <= op_d;
      mask_on_q <= mask_on_d;
      rem_q     <= rem_d;
      hbl_q     <= hbl_d;
      key_q     <= key_d;
      pos_q     <= pos_d;
    end
  end

  `WSFD_ASSERT_IMP(a_empty_marker, res_vld_o && !res_o.has_byte, res_o.last && (res_o.data_byte == 8'd0), "empty frame marker malformed")
  `WSFD_ASSERT_IMP(a_known_op, res_vld_o, opcode_known(res_o.frame_opcode), "result for unknown opcode")
  `WSFD_ASSERT_NXT(a_payload_end, adv_i && (phase_q == PH_PAYLOAD) && (rem_q == 64'd1), phase_q == PH_HDR0, "payload end missed")
  `WSFD_ASSERT_NXT(a_hdr1_leaves, adv_i && (phase_q == PH_HDR1), phase_q != PH_HDR1, "stuck on second header byte")
  `WSFD_ASSERT_IMP(a_payload_len, phase_q == PH_PAYLOAD, rem_q != 64'd0, "payload phase with zero length")

endmodule

`default_nettype wire

[sv/wsfd_out_stage.sv]
`default_nettype none

`include "websocket_frame_deframer_core_macros.svh"

module wsfd_out_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           load_i,
  input  wire logic           res_vld_i,
  input  wire wsfd_pkg::res_t res_i,
  output logic                space_o,
  output logic                vld_o,
  output wsfd_pkg::res_t      res_o,
  input  wire logic           ready_i
);

  import wsfd_pkg::*;

  logic vld_q;
  res_t res_q;

  // register can take a new result when empty or being drained
  assign space_o = !vld_q || ready_i;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load_i) begin
      vld_q <= res_vld_i;
    end else if (ready_i) begin
      vld_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load_i && res_vld_i) begin
      res_q <= res_i;
    end
  end

  assign vld_o = vld_q;
  assign res_o = res_q;

  `WSFD_ASSERT_IMP(a_no_overrun, load_i, space_o, "result loaded over a pending transaction")
  `WSFD_ASSERT_NXT(a_loaded, load_i && res_vld_i, vld_q, "loaded result not presented")
  `WSFD_ASSERT_NXT(a_retained, vld_q && !ready_i, vld_q, "pending result dropped")

endmodule

`default_nettype wire

[sv/websocket_frame_deframer_core.sv]
// RFC 6455 frame deframer: takes one received stream byte per rx_i transaction, frames back
// to back, and gives one res_o transaction per payload byte of a frame with opcode text,
// binary, close, ping or pong, unmasked with the frame's key and marked last on the final
// byte; a zero-length frame gives one empty marker (has_byte 0, last 1) and frames with other
// opcodes are swallowed. Header bytes give no output besides that marker. One byte is accepted
// every cycle while res_o keeps up; a byte is held in the input register and is then parsed in
// a single step into the result register, from which res_o offers its result until taken. While
// res_o stalls the block holds one byte and one result and then stalls rx_i. FIN and RSV bits
// are ignored and a 64-bit length is used in full.
`default_nettype none

module websocket_frame_deframer_core (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  wsfd_in_if.sink     rx_i,
  wsfd_res_if.source  res_o
);

  import wsfd_pkg::*;

  logic       in_vld;
  logic [7:0] in_byte;
  logic       adv;
  logic       space;
  logic       res_vld;
  res_t       res_nxt;
  res_t       res_cur;

  // a buffered byte is parsed when the result register can take its outcome
  assign adv = in_vld && space;

  wsfd_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (rx_i.valid),
    .rx_byte_i (rx_i.rx_byte),
    .ready_o   (rx_i.ready),
    .adv_i     (adv),
    .vld_o     (in_vld),
    .rx_byte_o (in_byte)
  );

  wsfd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .rx_byte_i (in_byte),
    .res_vld_o (res_vld),
    .res_o     (res_nxt)
  );

  wsfd_out_stage u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (adv),
    .res_vld_i (res_vld),
    .res_i     (res_nxt),
    .space_o   (space),
    .vld_o     (res_o.valid),
    .res_o     (res_cur),
    .ready_i   (res_o.ready)
  );

  // result fields onto the channel
  assign res_o.data_byte    = res_cur.data_byte;
  assign res_o.frame_opcode = res_cur.frame_opcode;
  assign res_o.has_byte     = res_cur.has_byte;
  assign res_o.last         = res_cur.last;

endmodule

`default_nettype wire
